### design/dsfr_pkg.sv
// Shared types and constants for the DLE/STX frame receiver.
package dsfr_pkg;

  localparam logic [7:0] CH_DLE  = 8'h10;
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CK_SEED = 8'h12;
  localparam logic [7:0] MAX_FRAME_BYTES_RESET = 8'd64;
  localparam logic [7:0] COUNT_SAT = 8'hff;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_WAIT_STX = 3'd1,
    PH_DEST     = 3'd2,
    PH_MSGID    = 3'd3,
    PH_DATA     = 3'd4,
    PH_DATA_DLE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_FAIL = 2'd1,
    ST_GOOD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FRAMING  = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_t;

endpackage

### design/dsfr_if.sv
// Input and result channel interfaces of the frame receiver.
interface dsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  error_kind;
  logic [7:0]  frame_length;
  logic [7:0]  dest_addr;
  logic [7:0]  message_id;
  logic [15:0] good_frame_count;
  logic [15:0] bad_data_count;
  logic [15:0] checksum_error_count;

  modport source (
    output valid, output status, output error_kind, output frame_length,
    output dest_addr, output message_id, output good_frame_count,
    output bad_data_count, output checksum_error_count, input ready
  );
  modport sink (
    input valid, input status, input error_kind, input frame_length,
    input dest_addr, input message_id, input good_frame_count,
    input bad_data_count, input checksum_error_count, output ready
  );
endinterface

### design/dle_stx_frame_receiver_unit.sv
// DLE/STX framed byte receiver with additive checksum, top level.
// An accepted item's result is registered in the output register and is seen there in the next cycle.
// Throughput: one item per cycle; the single output register sets it, and the
// input is held off only while that register holds a result not yet taken.
// Reset (rst, synchronous): parser back to hunting, counters and held bytes
// cleared, max_frame_bytes back to 64, output register empty.
module dle_stx_frame_receiver_unit
  import dsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  dsfr_in_if.sink    in_ch,
  dsfr_out_if.source out_ch
);

  logic [7:0]  max_frame_bytes;
  phase_t      phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [7:0]  byte_before_last, byte_before_last_next;
  logic [7:0]  held_dest, held_dest_next;
  logic [7:0]  held_msg_id, held_msg_id_next;
  logic [15:0] good_frames, good_frames_next;
  logic [15:0] bad_data, bad_data_next;
  logic [15:0] checksum_errors, checksum_errors_next;
  status_t     status_next;
  err_t        err_next;

  logic       accept;
  logic [7:0] b;
  logic [8:0] count_inc;
  logic       overflow;
  logic [7:0] expect_ck;
  logic [7:0] take_count;

  assign b         = in_ch.rx_byte;
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign count_inc = {1'b0, byte_count} + 9'd1;
  assign overflow  = count_inc > {1'b0, max_frame_bytes};
  assign take_count = (byte_count == COUNT_SAT) ? byte_count : count_inc[7:0];
  assign expect_ck = CK_SEED + running_sum - last_byte - byte_before_last;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT:     phase_next = (b == CH_DLE) ? PH_WAIT_STX : PH_HUNT;
      PH_WAIT_STX: phase_next = (b == CH_STX) ? PH_DEST : PH_HUNT;
      PH_DEST:     phase_next = PH_MSGID;
      PH_MSGID:    phase_next = PH_DATA;
      PH_DATA: begin
        if (overflow) phase_next = PH_HUNT;
        else if (b == CH_DLE) phase_next = PH_DATA_DLE;
        else phase_next = PH_DATA;
      end
      PH_DATA_DLE: phase_next = (b == CH_ETX) ? PH_HUNT : PH_DATA;
      default:     phase_next = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    byte_count_next       = byte_count;
    running_sum_next      = running_sum;
    last_byte_next        = last_byte;
    byte_before_last_next = byte_before_last;
    held_dest_next        = held_dest;
    held_msg_id_next      = held_msg_id;
    good_frames_next      = good_frames;
    bad_data_next         = bad_data;
    checksum_errors_next  = checksum_errors;
    status_next           = ST_BUSY;
    err_next              = ERR_NONE;
    case (phase)
      PH_HUNT: begin
        byte_count_next       = '0;
        running_sum_next      = '0;
        last_byte_next        = '0;
        byte_before_last_next = '0;
        held_dest_next        = '0;
        held_msg_id_next      = '0;
        if (b != CH_DLE) begin
          bad_data_next = bad_data + 16'd1;
          status_next   = ST_FAIL;
          err_next      = ERR_FRAMING;
        end
      end
      PH_WAIT_STX: begin
        if (b != CH_STX) begin
          bad_data_next = bad_data + 16'd1;
          status_next   = ST_FAIL;
          err_next      = ERR_FRAMING;
        end
      end
      PH_DEST, PH_MSGID, PH_DATA: begin
        byte_count_next       = take_count;
        running_sum_next      = running_sum + b;
        byte_before_last_next = last_byte;
        last_byte_next        = b;
        if (phase == PH_DEST) held_dest_next = b;
        if (phase == PH_MSGID) held_msg_id_next = b;
        if (phase == PH_DATA && overflow) begin
          bad_data_next = bad_data + 16'd1;
          status_next   = ST_FAIL;
          err_next      = ERR_LENGTH;
        end
      end
      PH_DATA_DLE: begin
        if (b == CH_ETX) begin
          if (expect_ck == byte_before_last) begin
            good_frames_next = good_frames + 16'd1;
            status_next      = ST_GOOD;
          end else begin
            checksum_errors_next = checksum_errors + 16'd1;
            status_next          = ST_FAIL;
            err_next             = ERR_CHECKSUM;
          end
        end else begin
          // byte after a body DLE: taken without the length check
          byte_count_next       = take_count;
          running_sum_next      = running_sum + b;
          byte_before_last_next = last_byte;
          last_byte_next        = b;
        end
      end
      default: begin
        bad_data_next = bad_data + 16'd1;
        status_next   = ST_FAIL;
        err_next      = ERR_FRAMING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes  <= MAX_FRAME_BYTES_RESET;
      phase            <= PH_HUNT;
      byte_count       <= '0;
      running_sum      <= '0;
      last_byte        <= '0;
      byte_before_last <= '0;
      held_dest        <= '0;
      held_msg_id      <= '0;
      good_frames      <= '0;
      bad_data         <= '0;
      checksum_errors  <= '0;
      out_ch.valid     <= 1'b0;
    end else begin
      if (cfg_we) max_frame_bytes <= cfg_wdata;
      if (accept) begin
        phase            <= phase_next;
        byte_count       <= byte_count_next;
        running_sum      <= running_sum_next;
        last_byte        <= last_byte_next;
        byte_before_last <= byte_before_last_next;
        held_dest        <= held_dest_next;
        held_msg_id      <= held_msg_id_next;
        good_frames      <= good_frames_next;
        bad_data         <= bad_data_next;
        checksum_errors  <= checksum_errors_next;
        out_ch.valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.status               <= status_next;
      out_ch.error_kind           <= err_next;
      out_ch.frame_length         <= byte_count_next;
      out_ch.dest_addr            <= held_dest_next;
      out_ch.message_id           <= held_msg_id_next;
      out_ch.good_frame_count     <= good_frames_next;
      out_ch.bad_data_count       <= bad_data_next;
      out_ch.checksum_error_count <= checksum_errors_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result register not empty after reset");
  a_good_no_error: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_GOOD |-> out_ch.error_kind == ERR_NONE)
    else $error("good frame reported with an error kind");
  a_fail_has_error: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_FAIL |-> out_ch.error_kind != ERR_NONE)
    else $error("failed item reported without an error kind");
  a_counters_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(good_frames) && $stable(bad_data) && $stable(checksum_errors))
    else $error("statistics changed without an accepted item");
`endif

endmodule
